@@ hdl/sha1_pkg.sv @@
// sha-1 engine shared types, constants and helper functions
`default_nettype none
package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } fq_t;

  localparam int ROUNDS = 80;
  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_IDX = 3'd4;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // merge one byte into the word being built, first byte of a word clears it
  function automatic logic [31:0] put_byte(input logic [31:0] cur,
                                           input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    case (pos)
      2'd0:    r = {b, 24'h000000};
      2'd1:    r = cur | {8'h00, b, 16'h0000};
      2'd2:    r = cur | {16'h0000, b, 8'h00};
      2'd3:    r = cur | {24'h000000, b};
      default: r = cur;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/sha1_hash_engine.sv @@
// sha-1 hash engine top level
//
//   channel   direction  handshake        payload
//   request   in         push / full      data_byte, byte_valid, end_of_message
//   digest    out        pop / empty      digest_word, word_index, last_word
//
// a byte request is taken while the back end is idle; the 64th byte of a block
// then runs 80 rounds of one shared round unit plus the chaining add.
// an end mark adds one padded block, or two when 56 or more bytes are pending.
// the digest sits in its own register, so bytes of the next message keep
// flowing until the next digest is ready while five words still wait.
// rst is synchronous and clears the queue, state and chaining words.
`default_nettype none
module sha1_hash_engine
  import sha1_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  item_t in_item;
  fq_t   q;
  logic  q_pop;

  assign in_item.data_byte      = data_byte;
  assign in_item.byte_valid     = byte_valid;
  assign in_item.end_of_message = end_of_message;

  sha1_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .q(q),
    .q_pop(q_pop)
  );

  sha1_back u_back (
    .clk(clk),
    .rst(rst),
    .q(q),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .digest_word(digest_word),
    .word_index(word_index),
    .last_word(last_word)
  );

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (word_index <= LAST_IDX))
    else $error("digest word index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_word == (word_index == LAST_IDX)))
    else $error("last word flag does not match index");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_word) |=>
      (!empty && word_index == $past(word_index) + 3'd1))
    else $error("digest words not delivered in order");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && last_word) |=> (empty || word_index == 3'd0))
    else $error("new digest does not start at word zero");

endmodule
`default_nettype wire

@@ hdl/sha1_front.sv @@
// input queue: accepts requests and drops those that carry neither byte nor end mark
`default_nettype none
module sha1_front
  import sha1_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire item_t in_item,
  output fq_t       q,
  input  wire logic q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic          store;
  logic          take;

  assign full  = (count == CNT_FULL);
  assign store = push && !full && (in_item.byte_valid || in_item.end_of_message);
  assign take  = q_pop && (count != '0);

  assign q.avail = (count != '0);
  assign q.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (store) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (store && !take) begin
        count <= count + 1'b1;
      end else if (take && !store) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sha1_back.sv @@
// block packing, padding, 80-round compression and digest output register
`default_nettype none
module sha1_back
  import sha1_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire fq_t   q,
  output logic       q_pop,
  output logic       empty,
  input  wire logic  pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_PAD2 = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [1:0] AFT_BYTE  = 2'd0;
  localparam logic [1:0] AFT_EXTRA = 2'd1;
  localparam logic [1:0] AFT_LAST  = 2'd2;

  logic [2:0]  state;
  logic [1:0]  after;
  logic        fin;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [31:0] h [5];
  logic [6:0]  rnd;
  logic        out_busy;
  logic [2:0]  cnt;

  logic [31:0] w [16];
  logic [31:0] cur;
  logic [31:0] a, b, c, d, e;
  logic [31:0] dig [5];

  logic [7:0]  pb_byte;
  logic [31:0] pb;
  logic [5:0]  fill_inc;
  logic [4:0]  first_free;
  logic [31:0] f, k, tmp, wnew, wx;

  assign q_pop = (state == S_IDLE) && q.avail;

  assign pb_byte  = (state == S_PAD) ? PAD_BYTE : q.item.data_byte;
  assign pb       = put_byte(cur, fill[1:0], pb_byte);
  assign fill_inc = fill + 6'd1;
  assign first_free = (fill_inc == '0) ? 5'd16 : 5'((7'(fill_inc) + 7'd3) >> 2);

  always_comb begin
    if (rnd < 7'd20) begin
      f = ((c ^ d) & b) ^ d;
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | ((b | c) & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp  = {a[26:0], a[31:27]} + f + e + k + w[0];
  assign wx   = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wnew = {wx[30:0], wx[31]};

  assign empty       = !out_busy;
  assign digest_word = dig[0];
  assign word_index  = cnt;
  assign last_word   = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      after      <= AFT_BYTE;
      fin        <= 1'b0;
      fill       <= '0;
      bit_length <= '0;
      rnd        <= '0;
      out_busy   <= 1'b0;
      cnt        <= '0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= H_INIT[i];
      end
    end else begin
      if (state != S_COMP) begin
        rnd <= '0;
      end
      case (state)
        S_IDLE: begin
          if (q.avail) begin
            fin <= q.item.end_of_message;
            if (q.item.byte_valid) begin
              bit_length <= bit_length + 64'd8;
              fill       <= fill_inc;
            end
            if (q.item.byte_valid && fill == 6'd63) begin
              after <= AFT_BYTE;
              state <= S_COMP;
            end else if (q.item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill  <= fill_inc;
          fin   <= 1'b0;
          after <= (fill >= 6'd56) ? AFT_EXTRA : AFT_LAST;
          state <= S_COMP;
        end
        S_PAD2: begin
          after <= AFT_LAST;
          state <= S_COMP;
        end
        S_COMP: begin
          rnd <= rnd + 7'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          case (after)
            AFT_BYTE:  state <= fin ? S_PAD : S_IDLE;
            AFT_EXTRA: state <= S_PAD2;
            AFT_LAST:  state <= S_DONE;
            default:   state <= S_IDLE;
          endcase
        end
        S_DONE: begin
          if (!out_busy) begin
            for (int i = 0; i < 5; i++) begin
              h[i] <= H_INIT[i];
            end
            fill       <= '0;
            bit_length <= '0;
            out_busy   <= 1'b1;
            cnt        <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_busy && pop) begin
        if (cnt == LAST_IDX) begin
          out_busy <= 1'b0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state != S_COMP) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
    case (state)
      S_IDLE: begin
        if (q.avail && q.item.byte_valid) begin
          cur           <= pb;
          w[fill[5:2]] <= pb;
        end
      end
      S_PAD: begin
        for (int i = 0; i < 16; i++) begin
          if (5'(i) >= first_free && (i < 14 || fill >= 6'd56)) begin
            w[i] <= '0;
          end
        end
        w[fill[5:2]] <= pb;
        if (fill < 6'd56) begin
          w[14] <= bit_length[63:32];
          w[15] <= bit_length[31:0];
        end
      end
      S_PAD2: begin
        for (int i = 0; i < 14; i++) begin
          w[i] <= '0;
        end
        w[14] <= bit_length[63:32];
        w[15] <= bit_length[31:0];
      end
      S_COMP: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= wnew;
      end
      S_DONE: begin
        if (!out_busy) begin
          for (int i = 0; i < 5; i++) begin
            dig[i] <= h[i];
          end
        end
      end
      default: begin
      end
    endcase
    if (out_busy && pop) begin
      for (int i = 0; i < 4; i++) begin
        dig[i] <= dig[i+1];
      end
    end
  end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// testbench for the sha-1 hash engine: digest tracker class, request and pop drivers
`timescale 1ns / 1ps

module tb;
  import sha1_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 1500;
  localparam int HOLD_AFTER_WORDS = 25;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  class digest_tracker;
    logic [31:0]  chain [5];
    logic [31:0]  blk [16];
    logic [5:0]   fill;
    logic [63:0]  bit_count;
    digest_exp_t  due_words [$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain = H_INIT;
      fill = '0;
      bit_count = '0;
    endfunction

    function void place_byte(logic [7:0] b);
      logic [3:0] idx;
      idx = fill[5:2];
      if (fill[1:0] == 2'd0) begin
        blk[idx] = '0;
      end
      blk[idx] = blk[idx] | ({24'h0, b} << (8 * (3 - fill[1:0])));
      fill = fill + 6'd1;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, tmp;
      w = blk;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          x = w[t];
        end else begin
          x = w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16];
          x = {x[30:0], x[31]};
          w[t % 16] = x;
        end
        if (t < 20) begin
          f = ((c ^ d) & b) ^ d;
          k = K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (t < 60) begin
          f = (b & c) | ((b | c) & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + x;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_request(logic [7:0] b, logic valid, logic eom);
      bit          extra;
      int          first_free;
      digest_exp_t exp_word;
      if (valid) begin
        bit_count += 64'd8;
        place_byte(b);
        if (fill == 6'd0) begin
          compress();
        end
      end
      if (!eom) begin
        return;
      end
      extra = (fill >= 6'd56);
      place_byte(PAD_BYTE);
      first_free = (int'(fill) + 3) >> 2;
      if (fill == 6'd0) begin
        first_free = 16;
      end
      for (int i = first_free; i < 16; i++) begin
        blk[i] = '0;
      end
      if (extra) begin
        compress();
        for (int i = 0; i < 14; i++) begin
          blk[i] = '0;
        end
      end
      blk[14] = bit_count[63:32];
      blk[15] = bit_count[31:0];
      compress();
      for (int i = 0; i < 5; i++) begin
        exp_word.word = chain[i];
        exp_word.idx = 3'(i);
        exp_word.last = (3'(i) == LAST_IDX);
        due_words.push_back(exp_word);
      end
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_exp_t exp_word;
      if (due_words.size() == 0) begin
        $error("unexpected digest word %h", word);
        errors++;
        return;
      end
      exp_word = due_words.pop_front();
      if (word !== exp_word.word) begin
        $error("digest_word: expected %h, got %h", exp_word.word, word);
        errors++;
      end
      if (idx !== exp_word.idx) begin
        $error("word_index: expected %0d, got %0d", exp_word.idx, idx);
        errors++;
      end
      if (last !== exp_word.last) begin
        $error("last_word: expected %0b, got %0b", exp_word.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_tracker sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int cycles = 0;

  sha1_hash_engine i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .empty          (empty),
    .pop            (pop),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // pops with a changing stall pattern, plus one long hold-off
  initial begin
    int  words_seen;
    int  mode;
    int  mode_left;
    bit  held;
    bit  want;
    words_seen = 0;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_word(digest_word, word_index, last_word);
        words_seen++;
      end
      if (!held && words_seen >= HOLD_AFTER_WORDS) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(1, 64);
        end
        mode_left--;
        case (mode)
          0:       want = 1'b1;
          1:       want = 1'($urandom_range(0, 1));
          default: want = ($urandom_range(0, 3) == 0);
        endcase
        pop <= want;
      end
    end
  end

  task automatic send_request(logic [7:0] b, logic valid, logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push <= 1'b1;
    data_byte <= b;
    byte_valid <= valid;
    end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(b, valid, eom);
    if (valid || eom) begin
      items_sent++;
    end
  endtask

  // message of n random bytes; the end mark rides on the last byte or follows alone
  task automatic send_message(int n);
    bit joined;
    joined = (n > 0) && $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(8'($urandom), 1'b0, 1'b0);
      end
      send_request(8'($urandom), 1'b1, joined && (i == n - 1));
    end
    if (!joined) begin
      send_request(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  initial begin
    int sel;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty message
    send_request(8'h00, 1'b0, 1'b1);
    // "abc" with the end mark on the last byte
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // extreme bytes, an ignored request, then end without a byte
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // single byte message
    send_request(8'hff, 1'b1, 1'b1);
    // end mark with stale data must not add a byte
    send_request(8'h5a, 1'b0, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        n = $urandom_range(0, 6);
      end else if (sel < 82) begin
        n = $urandom_range(54, 65);
      end else if (sel < 87) begin
        n = $urandom_range(119, 128);
      end else begin
        n = $urandom_range(7, 53);
      end
      send_message(n);
    end
    push <= 1'b0;

    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sha1_hash_engine.f @@
hdl/sha1_pkg.sv
hdl/sha1_front.sv
hdl/sha1_back.sv
hdl/sha1_hash_engine.sv
sim/tb.sv
